// ----- rtl/kct_pkg.sv -----
`timescale 1ns / 1ps
// Package holding the shared request codes, field widths and field positions of the k-mer count table.
package kct_pkg;

    typedef logic [1:0] req_t;

    localparam req_t REQ_BASE  = 2'd0;
    localparam req_t REQ_COUNT = 2'd1;
    localparam req_t REQ_FWD   = 2'd2;
    localparam req_t REQ_REV   = 2'd3;

    localparam int BASE_W      = 3;
    localparam int WEIGHT_W    = 16;
    localparam int KMER_W      = 16;
    localparam int OUT_COUNT_W = 32;
    localparam int WLEN_W      = 4;

    localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 4'd8;

    localparam int BASE_LSB   = 0;
    localparam int WEIGHT_LSB = BASE_LSB + BASE_W;
    localparam int QUERY_LSB  = WEIGHT_LSB + WEIGHT_W;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 48;

    localparam int SLOT_W  = 2;
    localparam int NSLOTS  = 4;
    localparam int NCNT_W  = 3;

endpackage

// ----- rtl/kmer_count_table_top.sv -----
`timescale 1ns / 1ps
// K-mer count table: rolling window, saturating count store and neighbour query engine.
//
//   channel   direction  handshake            payload
//   cfg       in         cfg_we               cfg_wdata = word_length
//   s_*       in         s_tvalid / s_tready  s_tdata, s_tuser = req_type, s_tlast = read_end
//   m_*       out        m_tvalid / m_tready  m_tdata, m_tuser = found, m_tlast = last
//
// Bases are taken one per cycle while no query holds the input; the store is read on acceptance
// and written back in the next cycle, the last write forwarded to the following read of the same entry.
// A count query holds the input until its result is loaded into the output register, a neighbour
// query until its last result is loaded, after the four reads through the single store read port.
// After reset the store clears its 2^(2*MAX_K) entries (65536 by default), one entry per cycle,
// before the first transaction is taken; configuration writes are taken.
// A stalled output holds a pending query result and with it the input side.
module kmer_count_table_top
    import kct_pkg::*;
#(
    parameter int MAX_K      = 8,
    parameter int COUNT_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [WLEN_W-1:0]    cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // base_code, read_weight, query_kmer, zero pad
    input  logic [1:0]           s_tuser,   // req_type
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // out_kmer, out_count
    output logic                 m_tuser,   // found
    output logic                 m_tlast
);

    localparam int KW     = 2 * MAX_K;
    localparam int DEPTH  = 1 << KW;
    localparam int FILL_W = $clog2(MAX_K + 1);
    localparam int SUM_W  = ((COUNT_BITS > WEIGHT_W) ? COUNT_BITS : WEIGHT_W) + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_RUN,
        ST_NBR_READ,
        ST_NBR_WAIT,
        ST_NBR_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RK_BASE,
        RK_COUNT,
        RK_NBR
    } rd_kind_t;

    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;

    state_t                state_reg, state_next;
    logic [KW-1:0]         clr_addr_reg, clr_addr_next;
    logic [WLEN_W-1:0]     wlen_reg, wlen_next;
    logic [KW-1:0]         win_reg, win_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic                  rd_vld_reg, rd_vld_next;
    rd_kind_t              rd_kind_reg, rd_kind_next;
    logic [KW-1:0]         rd_idx_reg, rd_idx_next;
    logic [WEIGHT_W-1:0]   rd_weight_reg, rd_weight_next;
    logic                  fwd_vld_reg, fwd_vld_next;
    logic [KW-1:0]         fwd_idx_reg, fwd_idx_next;
    logic [COUNT_BITS-1:0] fwd_val_reg, fwd_val_next;
    logic [KW-1:0]         nq_reg, nq_next;
    logic                  nrev_reg, nrev_next;
    logic [SLOT_W-1:0]     nslot_reg, nslot_next;
    logic [NCNT_W-1:0]     ncnt_reg, ncnt_next;
    logic [SLOT_W-1:0]     emit_reg, emit_next;
    logic [KW-1:0]         nk_reg [NSLOTS];
    logic [KW-1:0]         nk_next [NSLOTS];
    logic [COUNT_BITS-1:0] nc_reg [NSLOTS];
    logic [COUNT_BITS-1:0] nc_next [NSLOTS];
    logic                  out_vld_reg, out_vld_next;
    logic [KMER_W-1:0]     out_kmer_reg, out_kmer_next;
    logic [OUT_COUNT_W-1:0] out_count_reg, out_count_next;
    logic                  out_found_reg, out_found_next;
    logic                  out_last_reg, out_last_next;

    logic                  mem_we;
    logic [KW-1:0]         mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [KW-1:0]         mem_raddr;

    req_t                  in_req;
    logic [BASE_W-1:0]     in_base;
    logic [WEIGHT_W-1:0]   in_weight;
    logic [KMER_W-1:0]     in_query;
    logic                  accept;
    logic                  out_free;
    logic [WLEN_W-1:0]     k_eff;
    logic [WLEN_W:0]       shamt;
    logic [KW-1:0]         kmask;
    logic [KW-1:0]         q_masked;
    logic [KW-1:0]         win_shift;
    logic [FILL_W-1:0]     fill_inc;
    logic                  win_full;
    logic [KW-1:0]         base_idx;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] sat_sum;
    logic [KW-1:0]         cand;
    logic [NSLOTS-1:0]     ge;
    logic [NCNT_W-1:0]     pos;
    logic                  emit_last;

    assign in_req    = req_t'(s_tuser);
    assign in_base   = s_tdata[BASE_LSB +: BASE_W];
    assign in_weight = s_tdata[WEIGHT_LSB +: WEIGHT_W];
    assign in_query  = s_tdata[QUERY_LSB +: KMER_W];

    assign s_tready = (state_reg == ST_RUN) && !(rd_vld_reg && (rd_kind_reg == RK_COUNT));
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {out_count_reg, out_kmer_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        if (wlen_reg == '0)
        begin
            k_eff = WLEN_W'(1);
        end
        else if (wlen_reg > WLEN_W'(MAX_K))
        begin
            k_eff = WLEN_W'(MAX_K);
        end
        else
        begin
            k_eff = wlen_reg;
        end
    end

    assign shamt     = {k_eff, 1'b0};
    assign kmask     = ~({KW{1'b1}} << shamt);
    assign q_masked  = KW'(in_query) & kmask;
    assign win_shift = {win_reg[KW-3:0], in_base[1:0]};
    assign fill_inc  = (fill_reg < FILL_W'(MAX_K)) ? fill_reg + 1'b1 : fill_reg;
    assign win_full  = WLEN_W'(fill_inc) >= k_eff;
    assign base_idx  = win_shift & kmask;

    assign cur_cnt = (fwd_vld_reg && (fwd_idx_reg == rd_idx_reg)) ? fwd_val_reg : rd_data_reg;
    assign sum     = SUM_W'(cur_cnt) + SUM_W'(rd_weight_reg);
    assign sat_sum = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(sum);

    always_comb
    begin
        if (nrev_reg)
        begin
            cand = ((KW'(nslot_reg) << (shamt - (WLEN_W + 1)'(2))) | (nq_reg >> 2)) & kmask;
        end
        else
        begin
            cand = {nq_reg[KW-3:0], nslot_reg} & kmask;
        end
    end

    always_comb
    begin
        pos = '0;
        for (int j = 0; j < NSLOTS; j++)
        begin
            ge[j] = (NCNT_W'(j) < ncnt_reg) && (nc_reg[j] >= cur_cnt);
            pos   = pos + NCNT_W'(ge[j]);
        end
    end

    assign emit_last = ({1'b0, emit_reg} == (ncnt_reg - NCNT_W'(1)));

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        wlen_next      = cfg_we ? cfg_wdata : wlen_reg;
        win_next       = win_reg;
        fill_next      = fill_reg;
        rd_vld_next    = 1'b0;
        rd_kind_next   = rd_kind_reg;
        rd_idx_next    = rd_idx_reg;
        rd_weight_next = rd_weight_reg;
        fwd_vld_next   = fwd_vld_reg;
        fwd_idx_next   = fwd_idx_reg;
        fwd_val_next   = fwd_val_reg;
        nq_next        = nq_reg;
        nrev_next      = nrev_reg;
        nslot_next     = nslot_reg;
        ncnt_next      = ncnt_reg;
        emit_next      = emit_reg;
        nk_next        = nk_reg;
        nc_next        = nc_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_kmer_next  = out_kmer_reg;
        out_count_next = out_count_reg;
        out_found_next = out_found_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_waddr      = rd_idx_reg;
        mem_wdata      = sat_sum;
        mem_re         = 1'b0;
        mem_raddr      = base_idx;

        // The store data of a pending read is in the read register.
        if (rd_vld_reg)
        begin
            unique case (rd_kind_reg)
                RK_BASE:
                begin
                    mem_we       = 1'b1;
                    fwd_vld_next = 1'b1;
                    fwd_idx_next = rd_idx_reg;
                    fwd_val_next = sat_sum;
                end
                RK_COUNT:
                begin
                    if (out_free)
                    begin
                        out_vld_next   = 1'b1;
                        out_kmer_next  = KMER_W'(rd_idx_reg);
                        out_count_next = OUT_COUNT_W'(cur_cnt);
                        out_found_next = (cur_cnt != '0);
                        out_last_next  = 1'b1;
                    end
                    else
                    begin
                        rd_vld_next = 1'b1;
                    end
                end
                RK_NBR:
                begin
                    if (cur_cnt != '0)
                    begin
                        for (int j = 1; j < NSLOTS; j++)
                        begin
                            if (NCNT_W'(j) > pos)
                            begin
                                nk_next[j] = nk_reg[j-1];
                                nc_next[j] = nc_reg[j-1];
                            end
                        end
                        for (int j = 0; j < NSLOTS; j++)
                        begin
                            if (NCNT_W'(j) == pos)
                            begin
                                nk_next[j] = rd_idx_reg;
                                nc_next[j] = cur_cnt;
                            end
                        end
                        ncnt_next = ncnt_reg + NCNT_W'(1);
                    end
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (accept)
                begin
                    unique case (in_req)
                        REQ_BASE:
                        begin
                            if (in_base < BASE_OTHER)
                            begin
                                win_next  = win_shift;
                                fill_next = fill_inc;
                                if (win_full)
                                begin
                                    mem_re         = 1'b1;
                                    mem_raddr      = base_idx;
                                    rd_vld_next    = 1'b1;
                                    rd_kind_next   = RK_BASE;
                                    rd_idx_next    = base_idx;
                                    rd_weight_next = in_weight;
                                end
                            end
                            else
                            begin
                                win_next  = '0;
                                fill_next = '0;
                            end
                            if (s_tlast)
                            begin
                                win_next  = '0;
                                fill_next = '0;
                            end
                        end
                        REQ_COUNT:
                        begin
                            mem_re       = 1'b1;
                            mem_raddr    = q_masked;
                            rd_vld_next  = 1'b1;
                            rd_kind_next = RK_COUNT;
                            rd_idx_next  = q_masked;
                        end
                        REQ_FWD, REQ_REV:
                        begin
                            nq_next    = q_masked;
                            nrev_next  = (in_req == REQ_REV);
                            nslot_next = '0;
                            ncnt_next  = '0;
                            state_next = ST_NBR_READ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_NBR_READ:
            begin
                mem_re       = 1'b1;
                mem_raddr    = cand;
                rd_vld_next  = 1'b1;
                rd_kind_next = RK_NBR;
                rd_idx_next  = cand;
                nslot_next   = nslot_reg + 1'b1;
                if (nslot_reg == '1)
                begin
                    state_next = ST_NBR_WAIT;
                end
            end
            ST_NBR_WAIT:
            begin
                emit_next  = '0;
                state_next = ST_NBR_EMIT;
            end
            ST_NBR_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    if (ncnt_reg == '0)
                    begin
                        out_kmer_next  = '0;
                        out_count_next = '0;
                        out_found_next = 1'b0;
                        out_last_next  = 1'b1;
                        state_next     = ST_RUN;
                    end
                    else
                    begin
                        out_kmer_next  = KMER_W'(nk_reg[emit_reg]);
                        out_count_next = OUT_COUNT_W'(nc_reg[emit_reg]);
                        out_found_next = 1'b1;
                        out_last_next  = emit_last;
                        emit_next      = emit_reg + 1'b1;
                        if (emit_last)
                        begin
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            wlen_reg      <= WLEN_RESET;
            win_reg       <= '0;
            fill_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rd_kind_reg   <= RK_BASE;
            rd_idx_reg    <= '0;
            rd_weight_reg <= '0;
            fwd_vld_reg   <= 1'b0;
            fwd_idx_reg   <= '0;
            fwd_val_reg   <= '0;
            nq_reg        <= '0;
            nrev_reg      <= 1'b0;
            nslot_reg     <= '0;
            ncnt_reg      <= '0;
            emit_reg      <= '0;
            nk_reg        <= '{default: '0};
            nc_reg        <= '{default: '0};
            out_vld_reg   <= 1'b0;
            out_kmer_reg  <= '0;
            out_count_reg <= '0;
            out_found_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            wlen_reg      <= wlen_next;
            win_reg       <= win_next;
            fill_reg      <= fill_next;
            rd_vld_reg    <= rd_vld_next;
            rd_kind_reg   <= rd_kind_next;
            rd_idx_reg    <= rd_idx_next;
            rd_weight_reg <= rd_weight_next;
            fwd_vld_reg   <= fwd_vld_next;
            fwd_idx_reg   <= fwd_idx_next;
            fwd_val_reg   <= fwd_val_next;
            nq_reg        <= nq_next;
            nrev_reg      <= nrev_next;
            nslot_reg     <= nslot_next;
            ncnt_reg      <= ncnt_next;
            emit_reg      <= emit_next;
            nk_reg        <= nk_next;
            nc_reg        <= nc_next;
            out_vld_reg   <= out_vld_next;
            out_kmer_reg  <= out_kmer_next;
            out_count_reg <= out_count_next;
            out_found_reg <= out_found_next;
            out_last_reg  <= out_last_next;
        end
    end

    // A read and a write of the same entry at one edge return the old data; the
    // forwarding register above supplies the new value.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

// ----- test/kmer_count_table_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the k-mer count table: directed script, random reads and queries.
module kmer_count_table_top_tb;
    import kct_pkg::*;

    localparam int MAX_K       = 8;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        req_t        kind;
        logic [2:0]  base;
        logic [15:0] weight;
        logic        rend;
        logic [15:0] query;
    } table_req_t;

    typedef struct packed {
        logic [15:0] kmer;
        logic [31:0] count;
        logic        found;
        logic        last;
    } table_answer_t;

    typedef struct packed {
        table_req_t    rq;
        logic          typed;
        table_answer_t ans;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [WLEN_W-1:0]    cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    bit [31:0]     model_counts [65536];
    logic [15:0]   model_window;
    int unsigned   model_fill;
    logic [3:0]    model_wlen;
    logic [15:0]   seen_kmers [$];
    table_answer_t pending_answers [$];
    script_row_t   script [$];
    int            error_count = 0;
    bit            sender_idles;
    bit            receiver_idles;
    int            hold_off_requests;

    kmer_count_table_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic int unsigned eff_word_length();
        if (model_wlen == 4'd0)
            return 1;
        if (model_wlen > MAX_K)
            return MAX_K;
        return model_wlen;
    endfunction

    function automatic logic [15:0] kmer_mask(input int unsigned k);
        return 16'((32'd1 << (2 * k)) - 32'd1);
    endfunction

    function automatic void post_answer(input table_answer_t a);
        pending_answers = {pending_answers, a};
    endfunction

    // Updates the table copy and, when asked, queues the answers the request should produce.
    function automatic void predict_table(input table_req_t rq, input bit post);
        int unsigned   k;
        logic [15:0]   mask;
        logic [15:0]   q;
        logic [15:0]   cand;
        logic [15:0]   idx;
        logic [32:0]   sum;
        logic [31:0]   c;
        logic [15:0]   nk [4];
        logic [31:0]   nc [4];
        int            n;
        int            j;
        table_answer_t a;
        k    = eff_word_length();
        mask = kmer_mask(k);
        q    = rq.query & mask;
        n    = 0;
        if (rq.kind == REQ_BASE)
        begin
            if (rq.base > 3'd3)
            begin
                model_window = '0;
                model_fill   = 0;
            end
            else
            begin
                model_window = {model_window[13:0], rq.base[1:0]};
                if (model_fill < MAX_K)
                    model_fill++;
                if (model_fill >= k)
                begin
                    idx = model_window & mask;
                    sum = {1'b0, model_counts[idx]} + 33'(rq.weight);
                    if (sum > 33'hFFFF_FFFF)
                        sum = 33'hFFFF_FFFF;
                    model_counts[idx] = sum[31:0];
                    seen_kmers = {seen_kmers, idx};
                    if (seen_kmers.size() > 32)
                        void'(seen_kmers.pop_front());
                end
            end
            if (rq.rend)
            begin
                model_window = '0;
                model_fill   = 0;
            end
        end
        else if (rq.kind == REQ_COUNT)
        begin
            c = model_counts[q];
            a = '{kmer: q, count: c, found: (c != 0), last: 1'b1};
            if (post)
                post_answer(a);
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                if (rq.kind == REQ_FWD)
                    cand = ((q << 2) | 16'(i)) & mask;
                else
                    cand = 16'(((32'(i) << (2 * k - 2)) | (32'(q) >> 2)) & 32'(mask));
                c = model_counts[cand];
                if (c != 0)
                begin
                    j = n;
                    while (j > 0 && nc[j - 1] < c)
                    begin
                        nk[j] = nk[j - 1];
                        nc[j] = nc[j - 1];
                        j--;
                    end
                    nk[j] = cand;
                    nc[j] = c;
                    n++;
                end
            end
            if (post)
            begin
                if (n == 0)
                    post_answer('{kmer: '0, count: '0, found: 1'b0, last: 1'b1});
                for (int i = 0; i < n; i++)
                    post_answer('{kmer: nk[i], count: nc[i], found: 1'b1,
                                  last: (i == n - 1)});
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!sender_idles || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic int pick_stall();
        int r;
        r = $urandom_range(0, 99);
        if (!receiver_idles || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [15:0] pick_weight();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 16'd1;
        if (r < 75)
            return 16'($urandom_range(2, 4));
        if (r < 85)
            return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        return 16'($urandom);
    endfunction

    function automatic void add_row(input req_t kind, input logic [2:0] base,
                                    input logic [15:0] weight, input logic rend,
                                    input logic [15:0] query, input logic typed,
                                    input logic [15:0] a_kmer, input logic [31:0] a_count,
                                    input logic a_found);
        script_row_t r;
        r.rq    = '{kind: kind, base: base, weight: weight, rend: rend, query: query};
        r.typed = typed;
        r.ans   = '{kmer: a_kmer, count: a_count, found: a_found, last: 1'b1};
        script = {script, r};
    endfunction

    task automatic report_mismatch(input string field, input logic [47:0] got,
                                   input logic [47:0] want);
        $display("%0t: result %s is %0h, expected %0h", $time, field, got, want);
        error_count++;
    endtask

    task automatic send_item(input table_req_t rq, input bit typed, input table_answer_t ans);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, rq.query, rq.weight, rq.base};
        s_tuser  <= rq.kind;
        s_tlast  <= rq.rend;
        do
            @(posedge clk);
        while (!s_tready);
        predict_table(rq, !typed);
        if (typed)
            post_answer(ans);
    endtask

    task automatic set_word_length(input logic [3:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we     <= 1'b0;
        model_wlen = value;
    endtask

    task automatic random_traffic(input int items);
        int          issued;
        int          len;
        bit          narrow;
        logic [15:0] w;
        logic [15:0] mask;
        logic [15:0] x;
        logic [15:0] hi;
        table_req_t  rq;
        issued = 0;
        while (issued < items)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                begin
                    len    = $urandom_range(1, 12);
                    narrow = ($urandom_range(0, 1) == 0);
                    w      = pick_weight();
                    for (int i = 0; i < len; i++)
                    begin
                        rq.kind = REQ_BASE;
                        if ($urandom_range(0, 19) == 0)
                            rq.base = 3'($urandom_range(4, 7));
                        else
                            rq.base = 3'($urandom_range(0, narrow ? 1 : 3));
                        rq.weight = w;
                        rq.rend   = (i == len - 1) && ($urandom_range(0, 6) != 0);
                        rq.query  = 16'($urandom);
                        send_item(rq, 1'b0, '0);
                        issued++;
                    end
                end
                11, 12, 13, 14, 15, 16, 17:
                begin
                    mask = kmer_mask(eff_word_length());
                    x    = (seen_kmers.size() != 0) ?
                           seen_kmers[$urandom_range(0, seen_kmers.size() - 1)] :
                           16'($urandom);
                    x    = x & mask;
                    hi   = 16'($urandom);
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            rq.kind  = REQ_COUNT;
                            rq.query = x | (hi & ~mask);
                        end
                        1:
                        begin
                            rq.kind  = REQ_FWD;
                            rq.query = (x >> 2) | (hi & ~(mask >> 2));
                        end
                        default:
                        begin
                            rq.kind  = REQ_REV;
                            rq.query = (((x << 2) | (hi & 16'd3)) & mask) | (hi & ~mask);
                        end
                    endcase
                    rq.base   = 3'($urandom);
                    rq.weight = 16'($urandom);
                    rq.rend   = 1'($urandom);
                    send_item(rq, 1'b0, '0);
                    issued++;
                end
                default:
                begin
                    rq = '{kind: req_t'($urandom), base: 3'($urandom), weight: 16'($urandom),
                           rend: 1'($urandom), query: 16'($urandom)};
                    send_item(rq, 1'b0, '0);
                    issued++;
                end
            endcase
        end
    endtask

    task automatic run_phase(input logic [3:0] value, input int items, input bit hold);
        set_word_length(value);
        sender_idles   = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
        if (hold)
            hold_off_requests++;
        random_traffic(items);
    endtask

    initial
    begin
        int holds_done;
        m_tready   = 1'b0;
        holds_done = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            int stall;
            @(negedge clk);
            if (holds_done < hold_off_requests)
            begin
                holds_done++;
                stall = HOLD_CYCLES;
            end
            else
                stall = pick_stall();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        table_answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("with none awaited, kmer", 48'(m_tdata[15:0]), '0);
            else
            begin
                want = pending_answers.pop_front();
                if (m_tdata[15:0] !== want.kmer)
                    report_mismatch("out_kmer", 48'(m_tdata[15:0]), 48'(want.kmer));
                if (m_tdata[47:16] !== want.count)
                    report_mismatch("out_count", 48'(m_tdata[47:16]), 48'(want.count));
                if (m_tuser !== want.found)
                    report_mismatch("found", 48'(m_tuser), 48'(want.found));
                if (m_tlast !== want.last)
                    report_mismatch("last", 48'(m_tlast), 48'(want.last));
            end
        end
    end

    initial
    begin
        table_req_t rq;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        s_tvalid          = 1'b0;
        s_tdata           = '0;
        s_tuser           = REQ_BASE;
        s_tlast           = 1'b0;
        model_window      = '0;
        model_fill        = 0;
        model_wlen        = WLEN_RESET;
        sender_idles      = 1'b1;
        receiver_idles    = 1'b1;
        hold_off_requests = 0;

        // An empty table answers every query with a zero count or a single not-found.
        add_row(REQ_COUNT, 3'd0, 16'd1, 1'b0, 16'h0000, 1'b1, 16'h0000, 32'd0, 1'b0);
        add_row(REQ_COUNT, 3'd0, 16'd1, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF, 32'd0, 1'b0);
        add_row(REQ_FWD,   3'd0, 16'd1, 1'b0, 16'hFFFF, 1'b1, 16'h0000, 32'd0, 1'b0);
        add_row(REQ_REV,   3'd0, 16'd1, 1'b0, 16'h0000, 1'b1, 16'h0000, 32'd0, 1'b0);
        add_row(REQ_BASE,  3'd0, 16'd1,    1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd2, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd3, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd0, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd1, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd2, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd3, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd0, 16'h0000, 1'b0, 16'hFFFF, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  3'd7, 16'hFFFF, 1'b0, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_BASE,  BASE_OTHER, 16'd1, 1'b1, 16'h0000, 1'b0, '0, '0, 1'b0);
        add_row(REQ_COUNT, 3'd7, 16'hFFFF, 1'b1, 16'h1B1B, 1'b1, 16'h1B1B, 32'hFFFF, 1'b1);
        add_row(REQ_COUNT, 3'd0, 16'd1,    1'b0, 16'h6C6C, 1'b1, 16'h6C6C, 32'd0, 1'b0);
        add_row(REQ_FWD,   3'd0, 16'd1,    1'b0, 16'hC6C6, 1'b0, '0, '0, 1'b0);
        add_row(REQ_REV,   3'd0, 16'd1,    1'b0, 16'h6C6D, 1'b0, '0, '0, 1'b0);
        add_row(REQ_FWD,   3'd0, 16'd1,    1'b1, 16'h1B1B, 1'b0, '0, '0, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_item(script[i].rq, script[i].typed, script[i].ans);

        run_phase(4'd3, 40, 1'b0);
        run_phase(4'd15, 40, 1'b1);
        run_phase(4'd0, 40, 1'b0);
        run_phase(4'd2, 40, 1'b0);

        // Pile a large count onto one single-base entry, back to back.
        set_word_length(4'd1);
        sender_idles = 1'b0;
        rq = '{kind: REQ_BASE, base: 3'd3, weight: 16'hFFFF, rend: 1'b0, query: 16'h0000};
        repeat (24)
            send_item(rq, 1'b0, '0);
        rq = '{kind: REQ_COUNT, base: 3'd0, weight: 16'd1, rend: 1'b0, query: 16'h0003};
        send_item(rq, 1'b0, '0);
        rq.kind = REQ_FWD;
        send_item(rq, 1'b0, '0);
        rq.kind = REQ_REV;
        send_item(rq, 1'b0, '0);

        run_phase(4'd1, 40, 1'b0);
        run_phase(4'd8, 40, 1'b1);
        run_phase(4'd5, 40, 1'b0);
        run_phase(4'd9, 40, 1'b0);
        run_phase(4'd4, 40, 1'b0);
        run_phase(4'($urandom_range(0, 15)), 40, 1'b0);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/kct_pkg.sv
rtl/kmer_count_table_top.sv
test/kmer_count_table_top_tb.sv
